// ----- src/tpcf_pkg.sv -----
// Shared constants, register codes and helpers for the track panel crossing finder.
// No dependencies; used by tpcf_div, track_panel_crossing_finder and the testbench.
`default_nettype none

package tpcf_pkg;

	// coordinate width and derived widths
	localparam int CW       = 20;
	localparam int PW       = 2 * CW;         // product of two magnitudes
	localparam int YX_W     = 3 * CW;         // height, lower x, upper x
	localparam int Z_W      = 2 * CW;         // lower z, upper z
	localparam int CNT_W    = $clog2(CW);     // divider step counter
	localparam int NPANEL   = 4;
	localparam int PIDX_W   = $clog2(NPANEL);
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_YX     = 3'd0,
		REG_TOP_Z      = 3'd1,
		REG_BOTTOM_YX  = 3'd2,
		REG_BOTTOM_Z   = 3'd3,
		REG_ANODE_YX   = 3'd4,
		REG_ANODE_Z    = 3'd5,
		REG_CATHODE_YX = 3'd6,
		REG_CATHODE_Z  = 3'd7
	} reg_idx_t;

	localparam logic [PIDX_W-1:0] PANEL_LAST = PIDX_W'(NPANEL - 1);

	// magnitude of a difference of two CW-bit signed values; always fits CW bits
	function automatic logic [CW-1:0] mag(input logic [CW:0] v);
		logic [CW:0] a;
		a = v[CW] ? (~v + 1'b1) : v;
		return a[CW-1:0];
	endfunction

	// signed difference a - b, one bit wider
	function automatic logic [CW:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

endpackage

`default_nettype wire

// ----- src/tpcf_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle, CW steps.
// Uses tpcf_pkg; the high half of the dividend must be below the divisor.
`default_nettype none

module tpcf_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [tpcf_pkg::PW-1:0]  dividend,
	input  wire logic [tpcf_pkg::CW-1:0]  divisor,
	output logic                          done,
	output logic [tpcf_pkg::CW-1:0]       quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [tpcf_pkg::CNT_W-1:0]    cnt_q;
	logic [tpcf_pkg::CW-1:0]       rem_q;
	logic [tpcf_pkg::CW-1:0]       low_q;   // dividend bits shift out, quotient bits shift in
	logic [tpcf_pkg::CW-1:0]       dvs_q;

	logic [tpcf_pkg::CW:0]         trial;
	logic [tpcf_pkg::CW:0]         diff;
	logic                          qbit;

	assign trial = {rem_q, low_q[tpcf_pkg::CW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = ~diff[tpcf_pkg::CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tpcf_pkg::CNT_W'(tpcf_pkg::CW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[tpcf_pkg::PW-1:tpcf_pkg::CW];
			low_q <= dividend[tpcf_pkg::CW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[tpcf_pkg::CW-1:0] : trial[tpcf_pkg::CW-1:0];
			low_q <= {low_q[tpcf_pkg::CW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

`default_nettype wire

// ----- src/track_panel_crossing_finder.sv -----
// Top level: point intake, panel registers, segment/panel sequencer and result register.
// Uses tpcf_pkg and one tpcf_div for both crossing coordinates.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | pos_x, pos_y, pos_z, first_point, last_point
//  out      | out_valid / out_ready| hit, panel, cross_x, cross_y, cross_z
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// When no segment is tested, a point passes from idle straight to the done state. Each
// panel gets a range check, plus, when the plane is reached, a multiply and a 20-step
// divide for x, then for z, then the box test. in_ready is high only while idle. The
// result register holds a finished result until taken; a last point waits for it to
// empty. cfg_ready is always high.
`default_nettype none

module track_panel_crossing_finder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [tpcf_pkg::CW-1:0]         pos_x,
	input  wire logic [tpcf_pkg::CW-1:0]         pos_y,
	input  wire logic [tpcf_pkg::CW-1:0]         pos_z,
	input  wire logic                            first_point,
	input  wire logic                            last_point,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 hit,
	output logic [tpcf_pkg::PIDX_W-1:0]          panel,
	output logic [tpcf_pkg::CW-1:0]              cross_x,
	output logic [tpcf_pkg::CW-1:0]              cross_y,
	output logic [tpcf_pkg::CW-1:0]              cross_z,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tpcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tpcf_pkg::YX_W-1:0]       cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_TEST  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// panel registers
	logic [tpcf_pkg::YX_W-1:0] panel_yx_q [tpcf_pkg::NPANEL];
	logic [tpcf_pkg::Z_W-1:0]  panel_z_q  [tpcf_pkg::NPANEL];

	// current point and trajectory state
	logic [tpcf_pkg::CW-1:0]     pt_x_q, pt_y_q, pt_z_q;
	logic                        last_q;
	logic [tpcf_pkg::CW-1:0]     prev_x_q, prev_y_q, prev_z_q;
	logic                        have_prev_q;
	logic                        hit_found_q;
	logic [tpcf_pkg::PIDX_W-1:0] hit_panel_q;
	logic [tpcf_pkg::CW-1:0]     hit_x_q, hit_y_q, hit_z_q;

	// segment work registers
	logic [tpcf_pkg::PIDX_W-1:0] pidx_q;
	logic [tpcf_pkg::CW-1:0]     num_mag_q;
	logic [tpcf_pkg::CW-1:0]     dy_mag_q;
	logic                        sel_z_q;
	logic                        dneg_q;
	logic [tpcf_pkg::CW-1:0]     cx_q, cz_q;

	// result register
	logic                        out_valid_q;
	logic                        out_hit_q;
	logic [tpcf_pkg::PIDX_W-1:0] out_panel_q;
	logic [tpcf_pkg::CW-1:0]     out_x_q, out_y_q, out_z_q;

	// selected panel fields
	logic [tpcf_pkg::YX_W-1:0]   cur_yx;
	logic [tpcf_pkg::Z_W-1:0]    cur_z;
	logic signed [tpcf_pkg::CW-1:0] height, xl, xu, zl, zu;

	logic [tpcf_pkg::CW:0]       dy, num, dc;
	logic [tpcf_pkg::CW-1:0]     dy_mag, num_mag, dc_mag;
	logic                        reach;
	logic [tpcf_pkg::PW-1:0]     prod;
	logic                        div_start, div_done;
	logic [tpcf_pkg::CW-1:0]     quo;
	logic [tpcf_pkg::CW-1:0]     base;
	logic [tpcf_pkg::CW:0]       sum;
	logic                        inside_box;
	logic                        in_acc, out_acc, out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid_q && out_ready;
	assign out_load  = (state_q == ST_DONE) && last_q && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	assign cur_yx = panel_yx_q[pidx_q];
	assign cur_z  = panel_z_q[pidx_q];
	assign height = cur_yx[tpcf_pkg::YX_W-1:2*tpcf_pkg::CW];
	assign xl     = cur_yx[2*tpcf_pkg::CW-1:tpcf_pkg::CW];
	assign xu     = cur_yx[tpcf_pkg::CW-1:0];
	assign zl     = cur_z[2*tpcf_pkg::CW-1:tpcf_pkg::CW];
	assign zu     = cur_z[tpcf_pkg::CW-1:0];

	// plane reached with t in (0,1]
	assign dy      = tpcf_pkg::sdiff(pt_y_q, prev_y_q);
	assign num     = tpcf_pkg::sdiff(height, prev_y_q);
	assign dy_mag  = tpcf_pkg::mag(dy);
	assign num_mag = tpcf_pkg::mag(num);
	assign reach   = (dy != '0) && (num != '0) && (dy[tpcf_pkg::CW] == num[tpcf_pkg::CW])
		&& (num_mag <= dy_mag);

	// shared multiply ahead of the divider
	assign dc     = sel_z_q ? tpcf_pkg::sdiff(pt_z_q, prev_z_q) : tpcf_pkg::sdiff(pt_x_q, prev_x_q);
	assign dc_mag = tpcf_pkg::mag(dc);
	assign prod   = dc_mag * num_mag_q;
	assign div_start = (state_q == ST_MUL);

	tpcf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (dy_mag_q),
		.done     (div_done),
		.quotient (quo)
	);

	// crossing = start point plus or minus the truncated quotient; stays in range
	assign base = sel_z_q ? prev_z_q : prev_x_q;
	assign sum  = dneg_q ? ({base[tpcf_pkg::CW-1], base} - {1'b0, quo})
		: ({base[tpcf_pkg::CW-1], base} + {1'b0, quo});

	assign inside_box = ($signed(cx_q) > xl) && ($signed(cx_q) < xu)
		&& ($signed(cz_q) > zl) && ($signed(cz_q) < zu);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_yx_q <= '{default: '0};
			panel_z_q  <= '{default: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpcf_pkg::REG_TOP_YX:     panel_yx_q[0] <= cfg_data;
				tpcf_pkg::REG_TOP_Z:      panel_z_q[0]  <= cfg_data[tpcf_pkg::Z_W-1:0];
				tpcf_pkg::REG_BOTTOM_YX:  panel_yx_q[1] <= cfg_data;
				tpcf_pkg::REG_BOTTOM_Z:   panel_z_q[1]  <= cfg_data[tpcf_pkg::Z_W-1:0];
				tpcf_pkg::REG_ANODE_YX:   panel_yx_q[2] <= cfg_data;
				tpcf_pkg::REG_ANODE_Z:    panel_z_q[2]  <= cfg_data[tpcf_pkg::Z_W-1:0];
				tpcf_pkg::REG_CATHODE_YX: panel_yx_q[3] <= cfg_data;
				tpcf_pkg::REG_CATHODE_Z:  panel_z_q[3]  <= cfg_data[tpcf_pkg::Z_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			hit_found_q <= 1'b0;
			out_valid_q <= 1'b0;
			pidx_q      <= '0;
			sel_z_q     <= 1'b0;
		end else begin
			// a new result may replace the one taken in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pidx_q <= '0;
						if (first_point) begin
							have_prev_q <= 1'b0;
							hit_found_q <= 1'b0;
						end
						if (have_prev_q && !first_point && !hit_found_q) begin
							state_q <= ST_CHECK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CHECK: begin
					sel_z_q <= 1'b0;
					if (reach) begin
						state_q <= ST_MUL;
					end else if (pidx_q == tpcf_pkg::PANEL_LAST) begin
						state_q <= ST_DONE;
					end else begin
						pidx_q <= pidx_q + 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (sel_z_q) begin
							state_q <= ST_TEST;
						end else begin
							sel_z_q <= 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_TEST: begin
					if (inside_box) begin
						hit_found_q <= 1'b1;
						state_q     <= ST_DONE;
					end else if (pidx_q == tpcf_pkg::PANEL_LAST) begin
						state_q <= ST_DONE;
					end else begin
						pidx_q  <= pidx_q + 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						have_prev_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (out_load) begin
						have_prev_q <= 1'b0;
						hit_found_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pt_x_q <= pos_x;
			pt_y_q <= pos_y;
			pt_z_q <= pos_z;
			last_q <= last_point;
		end
		if ((state_q == ST_CHECK) && reach) begin
			num_mag_q <= num_mag;
			dy_mag_q  <= dy_mag;
		end
		if (state_q == ST_MUL) begin
			dneg_q <= dc[tpcf_pkg::CW];
		end
		if ((state_q == ST_DIV) && div_done) begin
			if (sel_z_q) begin
				cz_q <= sum[tpcf_pkg::CW-1:0];
			end else begin
				cx_q <= sum[tpcf_pkg::CW-1:0];
			end
		end
		if ((state_q == ST_TEST) && inside_box) begin
			hit_panel_q <= pidx_q;
			hit_x_q     <= cx_q;
			hit_y_q     <= height;
			hit_z_q     <= cz_q;
		end
		if ((state_q == ST_DONE) && !last_q) begin
			prev_x_q <= pt_x_q;
			prev_y_q <= pt_y_q;
			prev_z_q <= pt_z_q;
		end
		if (out_load) begin
			out_hit_q   <= hit_found_q;
			out_panel_q <= hit_found_q ? hit_panel_q : '0;
			out_x_q     <= hit_found_q ? hit_x_q : '0;
			out_y_q     <= hit_found_q ? hit_y_q : '0;
			out_z_q     <= hit_found_q ? hit_z_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign panel     = out_panel_q;
	assign cross_x   = out_x_q;
	assign cross_y   = out_y_q;
	assign cross_z   = out_z_q;

endmodule

`default_nettype wire

// ----- tb/track_panel_crossing_finder_tb.sv -----
// Testbench for track_panel_crossing_finder: directed table rows, then random trajectories
// under several panel settings; results checked against typed rows or a local predictor.
// Depends on tpcf_pkg and the track_panel_crossing_finder RTL only.

module track_panel_crossing_finder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpcf_pkg::*;

	localparam int LIMIT_CYCLES   = 1_500_000;
	localparam int SETTLE_CYCLES  = 250;
	localparam int HOLD_CYCLES    = 400;
	localparam int MAX_REPORTS    = 10;
	localparam int CONFIGURED_ROW = 3;

	localparam logic [PIDX_W-1:0] PANEL_TOP     = 2'd0;
	localparam logic [PIDX_W-1:0] PANEL_BOTTOM  = 2'd1;
	localparam logic [PIDX_W-1:0] PANEL_ANODE   = 2'd2;
	localparam logic [PIDX_W-1:0] PANEL_CATHODE = 2'd3;

	// panel settings
	localparam int SET_DIRECTED  = 0;
	localparam int SET_REALISTIC = 1;
	localparam int SET_EXTREME   = 2;
	localparam int SET_RAW       = 3;
	localparam int SET_ONES      = 4;
	localparam int SET_NARROW    = 5;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 first;
		logic                 last;
	} point_t;

	typedef struct packed {
		logic              hit;
		logic [PIDX_W-1:0] panel;
		logic [CW-1:0]     x;
		logic [CW-1:0]     y;
		logic [CW-1:0]     z;
	} crossing_t;

	typedef struct packed {
		point_t    pt;
		logic      typed;
		crossing_t want;
	} step_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CW-1:0]     pos_x;
	logic [CW-1:0]     pos_y;
	logic [CW-1:0]     pos_z;
	logic              first_point;
	logic              last_point;
	logic              out_valid;
	logic              out_ready;
	logic              hit;
	logic [PIDX_W-1:0] panel;
	logic [CW-1:0]     cross_x;
	logic [CW-1:0]     cross_y;
	logic [CW-1:0]     cross_z;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [YX_W-1:0]   cfg_data;

	// local copy of the panel registers and of the track state
	logic [YX_W-1:0]   shadow_yx [NPANEL];
	logic [Z_W-1:0]    shadow_z [NPANEL];
	longint            px, py, pz;
	bit                have_prev;
	bit                hit_found;
	logic [PIDX_W-1:0] hit_panel;
	longint            hx, hy, hz;

	crossing_t expected_crossings [$];
	step_t     directed_steps [$];
	crossing_t due;

	int     mismatches;
	int     results_checked;
	int     crossings_seen;
	int     points_sent;
	int     directed_points;
	int     settings_used;
	longint cycle_count;
	bit     no_gaps;
	bit     hold_req;

	track_panel_crossing_finder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.first_point (first_point),
		.last_point  (last_point),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.panel       (panel),
		.cross_x     (cross_x),
		.cross_y     (cross_y),
		.cross_z     (cross_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("run stopped after %0d cycles, %0d results outstanding",
				cycle_count, expected_crossings.size());
			$display("track_panel_crossing_finder_tb failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint field_of(input logic [YX_W-1:0] r, input int k);
		return longint'($signed(r[k*CW +: CW]));
	endfunction

	function automatic longint lerp(input longint c1, input longint c2, input longint nm,
			input longint dm);
		longint dc, q;
		dc = c2 - c1;
		q = ((dc < 0 ? -dc : dc) * nm) / dm;
		return (dc < 0) ? c1 - q : c1 + q;
	endfunction

	function automatic void clear_track();
		px = 0;
		py = 0;
		pz = 0;
		have_prev = 1'b0;
		hit_found = 1'b0;
		hit_panel = PANEL_TOP;
		hx = 0;
		hy = 0;
		hz = 0;
	endfunction

	task automatic advance_track(input point_t pt, output bit gives, output crossing_t res);
		longint x2, y2, z2, dy, num, nm, dm, cx, cz, h;
		int p;
		logic [PIDX_W-1:0] pi;
		x2 = longint'(pt.x);
		y2 = longint'(pt.y);
		z2 = longint'(pt.z);
		if (pt.first)
			clear_track();
		if (have_prev) begin
			// panels in fixed order; stop at the first one hit
			for (p = 0; p < NPANEL && !hit_found; p++) begin
				pi = p[PIDX_W-1:0];
				h = field_of(shadow_yx[pi], 2);
				dy = y2 - py;
				num = h - py;
				nm = (num < 0) ? -num : num;
				dm = (dy < 0) ? -dy : dy;
				if (dy != 0 && num != 0 && ((num > 0) == (dy > 0)) && nm <= dm) begin
					cx = lerp(px, x2, nm, dm);
					cz = lerp(pz, z2, nm, dm);
					if (cx > field_of(shadow_yx[pi], 1) && cx < field_of(shadow_yx[pi], 0) &&
							cz > field_of(shadow_z[pi], 1) && cz < field_of(shadow_z[pi], 0)) begin
						hit_found = 1'b1;
						hit_panel = pi;
						hx = cx;
						hy = h;
						hz = cz;
					end
				end
			end
		end
		px = x2;
		py = y2;
		pz = z2;
		have_prev = 1'b1;
		gives = pt.last;
		res.hit = hit_found;
		res.panel = hit_panel;
		res.x = hx[CW-1:0];
		res.y = hy[CW-1:0];
		res.z = hz[CW-1:0];
		if (pt.last)
			clear_track();
	endtask

	// ---------------------------------------------------------------- result check

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (expected_crossings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result with none pending: hit=%0d panel=%0d x=%0d y=%0d z=%0d",
						hit, panel, $signed(cross_x), $signed(cross_y), $signed(cross_z));
			end else begin
				due = expected_crossings.pop_front();
				if (due.hit)
					crossings_seen++;
				if (hit !== due.hit || panel !== due.panel || cross_x !== due.x ||
						cross_y !== due.y || cross_z !== due.z) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch at result %0d: expected hit=%0d panel=%0d x=%0d y=%0d z=%0d,",
							results_checked, due.hit, due.panel, $signed(due.x),
							$signed(due.y), $signed(due.z));
						$display("  got hit=%0d panel=%0d x=%0d y=%0d z=%0d", hit, panel,
							$signed(cross_x), $signed(cross_y), $signed(cross_z));
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	initial begin
		int waited;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// hold results back long enough for the block to stall its input
				hold_req = 1'b0;
				out_ready <= 1'b0;
				for (waited = 0; waited < HOLD_CYCLES; waited++)
					@(negedge clk);
			end else begin
				out_ready <= no_gaps || ($urandom_range(99) >= 9);
			end
		end
	end

	// ---------------------------------------------------------------- sender side

	task automatic offer_point(input point_t pt, input bit typed, input crossing_t want);
		bit gives;
		crossing_t res;
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= pt.x;
		pos_y <= pt.y;
		pos_z <= pt.z;
		first_point <= pt.first;
		last_point <= pt.last;
		// hold the request until the block takes it
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_track(pt, gives, res);
		if (gives)
			expected_crossings = {expected_crossings, (typed ? want : res)};
		points_sent++;
	endtask

	task automatic write_panel_reg(input reg_idx_t idx, input logic [YX_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx[0])
			shadow_z[idx[CFG_IDX_W-1:1]] = data[Z_W-1:0];
		else
			shadow_yx[idx[CFG_IDX_W-1:1]] = data;
	endtask

	function automatic reg_idx_t yx_reg(input int p);
		case (p)
			PANEL_TOP:    return REG_TOP_YX;
			PANEL_BOTTOM: return REG_BOTTOM_YX;
			PANEL_ANODE:  return REG_ANODE_YX;
			default:      return REG_CATHODE_YX;
		endcase
	endfunction

	function automatic reg_idx_t z_reg(input int p);
		case (p)
			PANEL_TOP:    return REG_TOP_Z;
			PANEL_BOTTOM: return REG_BOTTOM_Z;
			PANEL_ANODE:  return REG_ANODE_Z;
			default:      return REG_CATHODE_Z;
		endcase
	endfunction

	task automatic load_panels(input int kind);
		logic [CW-1:0] h, xl, xu, zl, zu;
		logic [31:0] junk;
		int p, c, r;
		for (p = 0; p < NPANEL; p++) begin
			junk = $urandom;
			h = CW'($urandom_range(60000) - 30000);
			c = int'($urandom_range(10000)) - 5000;
			r = $urandom_range(40000, 2000);
			xl = CW'(c - r);
			xu = CW'(c + r);
			c = int'($urandom_range(10000)) - 5000;
			r = $urandom_range(40000, 2000);
			zl = CW'(c - r);
			zu = CW'(c + r);
			case (kind)
				SET_DIRECTED: begin
					case (p)
						PANEL_TOP:    h = CW'(1000);
						PANEL_BOTTOM: h = CW'(-1000);
						PANEL_ANODE:  h = CW'(300);
						default:      h = CW'(-300);
					endcase
					xl = CW'((p == PANEL_ANODE) ? -100 : (p == PANEL_CATHODE) ? 100 : -5000);
					xu = CW'((p == PANEL_ANODE) ? 100 : (p == PANEL_CATHODE) ? -100 : 5000);
					zl = CW'((p == PANEL_ANODE) ? -100 : -5000);
					zu = CW'((p == PANEL_ANODE) ? 100 : 5000);
				end
				SET_EXTREME: begin
					case (p)
						PANEL_TOP:    h = 20'h7FFFF;
						PANEL_BOTTOM: h = 20'h80000;
						PANEL_ANODE:  h = '0;
						default:      h = '1;
					endcase
					xl = 20'h80000;
					xu = 20'h7FFFF;
					zl = 20'h80000;
					zu = 20'h7FFFF;
				end
				SET_NARROW: begin
					xl = CW'($urandom_range(4000) - 2000);
					xu = CW'(xl + 2);
					zl = CW'($urandom_range(4000) - 2000);
					zu = CW'(zl + 2);
				end
				default: ;
			endcase
			if (kind == SET_RAW) begin
				write_panel_reg(yx_reg(p), YX_W'({$urandom, $urandom}));
				write_panel_reg(z_reg(p), YX_W'({$urandom, $urandom}));
			end else if (kind == SET_ONES) begin
				write_panel_reg(yx_reg(p), '1);
				write_panel_reg(z_reg(p), '1);
			end else begin
				write_panel_reg(yx_reg(p), {h, xl, xu});
				// junk above bit 39 must be dropped by the block
				write_panel_reg(z_reg(p), {junk[CW-1:0], zl, zu});
			end
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// drop the request line and let the block run dry before touching registers
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_crossings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] pick_y();
		int p;
		logic [CW-1:0] h;
		p = $urandom_range(NPANEL - 1);
		h = shadow_yx[p[PIDX_W-1:0]][YX_W-1 -: CW];
		case ($urandom_range(5))
			0:       return CW'($urandom);
			1:       return CW'(h + $urandom_range(2) - 1);
			default: return CW'(h + $urandom_range(6000) - 3000);
		endcase
	endfunction

	function automatic logic [CW-1:0] pick_xz(input bit on_z);
		int p;
		logic [CW-1:0] b;
		p = $urandom_range(NPANEL - 1);
		if (on_z)
			b = $urandom_range(1) ? shadow_z[p[PIDX_W-1:0]][CW-1:0]
				: shadow_z[p[PIDX_W-1:0]][2*CW-1:CW];
		else
			b = $urandom_range(1) ? shadow_yx[p[PIDX_W-1:0]][CW-1:0]
				: shadow_yx[p[PIDX_W-1:0]][2*CW-1:CW];
		case ($urandom_range(5))
			0:       return CW'($urandom);
			1:       return CW'(b + $urandom_range(4) - 2);
			2:       return CW'($urandom_range(16000) - 8000);
			default: return CW'(b + $urandom_range(8000) - 4000);
		endcase
	endfunction

	task automatic run_random_points(input int budget);
		point_t pt;
		crossing_t none;
		int len, i, start;
		start = points_sent;
		none = '0;
		while (points_sent - start < budget) begin
			if ($urandom_range(9) == 0) begin
				// stray point: any coordinates, any flags
				pt.x = CW'($urandom);
				pt.y = CW'($urandom);
				pt.z = CW'($urandom);
				pt.first = 1'($urandom_range(1));
				pt.last = 1'($urandom_range(1));
				offer_point(pt, 1'b0, none);
			end else begin
				len = ($urandom_range(3) == 0) ? $urandom_range(10, 2) : $urandom_range(4, 1);
				for (i = 0; i < len; i++) begin
					pt.x = pick_xz(1'b0);
					pt.y = pick_y();
					pt.z = pick_xz(1'b1);
					// now and then drop the start flag
					pt.first = (i == 0) && ($urandom_range(7) != 0);
					pt.last = (i == len - 1);
					offer_point(pt, 1'b0, none);
				end
			end
		end
	endtask

	task automatic run_phase(input int kind, input int budget, input bit steady, input bit squeeze);
		settle_idle();
		load_panels(kind);
		no_gaps = steady;
		if (squeeze)
			hold_req = 1'b1;
		run_random_points(budget);
		no_gaps = 1'b0;
	endtask

	task automatic add_row(input int x, input int y, input int z, input bit first, input bit last,
			input bit typed, input bit h, input int pnl, input int cx, input int cy, input int cz);
		step_t s;
		s.pt.x = x[CW-1:0];
		s.pt.y = y[CW-1:0];
		s.pt.z = z[CW-1:0];
		s.pt.first = first;
		s.pt.last = last;
		s.typed = typed;
		s.want.hit = h;
		s.want.panel = pnl[PIDX_W-1:0];
		s.want.x = cx[CW-1:0];
		s.want.y = cy[CW-1:0];
		s.want.z = cz[CW-1:0];
		directed_steps = {directed_steps, s};
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		first_point = 1'b0;
		last_point = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TOP_YX;
		cfg_data = '0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		for (i = 0; i < NPANEL; i++) begin
			shadow_yx[i[PIDX_W-1:0]] = '0;
			shadow_z[i[PIDX_W-1:0]] = '0;
		end
		clear_track();

		//       x        y        z    first last typed hit panel        cx   cy    cz
		// registers still at reset: every panel is empty
		add_row(0,       0,       0,       1, 1, 1, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       2000,    0,       1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       -2000,   0,       0, 1, 1, 0, PANEL_TOP,     0,   0,    0);
		// top 1000, bottom -1000, anode 300 (narrow), cathode -300 with inverted x
		add_row(0,       2000,    0,       1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       0,       0,       0, 1, 1, 1, PANEL_TOP,     0,   1000, 0);
		// crosses top and bottom; top wins and the later bottom crossing is ignored
		add_row(40,      2000,    -40,     1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       -2000,   0,       0, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       0,       0,       0, 1, 1, 1, PANEL_TOP,     30,  1000, -30);
		// flat segment lying in the top plane
		add_row(10,      1000,    10,      1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(20,      1000,    20,      0, 1, 1, 0, PANEL_TOP,     0,   0,    0);
		// starts on the plane
		add_row(1000,    1000,    0,       1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(1000,    0,       0,       0, 1, 1, 0, PANEL_TOP,     0,   0,    0);
		// ends exactly on the anode plane
		add_row(0,       500,     0,       1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       300,     0,       0, 1, 1, 1, PANEL_ANODE,   0,   300,  0);
		// reaches only the cathode, whose bounds are inverted
		add_row(0,       0,       0,       1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       -600,    0,       0, 1, 1, 0, PANEL_TOP,     0,   0,    0);
		// crossing lands on the top x bound itself
		add_row(5000,    2000,    0,       1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(5000,    0,       0,       0, 1, 1, 0, PANEL_TOP,     0,   0,    0);
		// new track without its start flag
		add_row(0,       2000,    0,       0, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(0,       0,       0,       0, 1, 1, 1, PANEL_TOP,     0,   1000, 0);
		// quotient truncated toward zero
		add_row(0,       2000,    0,       1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(-7,      -1000,   7,       0, 1, 0, 0, PANEL_TOP,     0,   0,    0);
		// coordinate extremes
		add_row(-524288, -524288, -524288, 1, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(524287,  524287,  524287,  0, 0, 0, 0, PANEL_TOP,     0,   0,    0);
		add_row(-524288, 524287,  524287,  0, 1, 0, 0, PANEL_TOP,     0,   0,    0);

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (i = 0; i < directed_steps.size(); i++) begin
			if (i == CONFIGURED_ROW) begin
				settle_idle();
				load_panels(SET_DIRECTED);
			end
			offer_point(directed_steps[i].pt, directed_steps[i].typed, directed_steps[i].want);
		end
		directed_points = points_sent;

		run_phase(SET_REALISTIC, 260, 1'b0, 1'b0);
		run_phase(SET_EXTREME,   260, 1'b0, 1'b0);
		run_phase(SET_RAW,       260, 1'b0, 1'b0);
		run_phase(SET_REALISTIC, 260, 1'b0, 1'b1);
		run_phase(SET_NARROW,    260, 1'b0, 1'b0);
		run_phase(SET_ONES,      200, 1'b0, 1'b0);
		run_phase(SET_REALISTIC, 325, 1'b1, 1'b0);
		settle_idle();

		$display("Sent %0d points (%0d from the directed table) under %0d panel settings,",
			points_sent, directed_points, settings_used);
		$display("including a long result stall and a gap-free stretch; %0d results, %0d crossings.",
			results_checked, crossings_seen);
		if (mismatches == 0 && expected_crossings.size() == 0) begin
			$display("track_panel_crossing_finder_tb passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_crossings.size());
			$display("track_panel_crossing_finder_tb failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/tpcf_pkg.sv
src/tpcf_div.sv
src/track_panel_crossing_finder.sv
tb/track_panel_crossing_finder_tb.sv
